// ===== src/matrix3_inverse_top_assert.svh =====
// Assertion macros for the 3x3 inverse pipeline.
// Each macro expects clk and rst_n in scope.
`ifndef MATRIX3_INVERSE_TOP_ASSERT_SVH
`define MATRIX3_INVERSE_TOP_ASSERT_SVH

// Same-cycle implication.
`define M3INV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication after a fixed number of cycles.
`define M3INV_ASSERT_AFTER(label, ante, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

// ===== src/m3inv_pkg.sv =====
`default_nettype none

package m3inv_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int THR_W         = 31;
    localparam logic [THR_W-1:0] THR_RESET = 31'd1;

    typedef struct packed {
        logic signed [31:0] m_r0c0;
        logic signed [31:0] m_r0c1;
        logic signed [31:0] m_r0c2;
        logic signed [31:0] m_r1c0;
        logic signed [31:0] m_r1c1;
        logic signed [31:0] m_r1c2;
        logic signed [31:0] m_r2c0;
        logic signed [31:0] m_r2c1;
        logic signed [31:0] m_r2c2;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] inv_r0c0;
        logic signed [31:0] inv_r0c1;
        logic signed [31:0] inv_r0c2;
        logic signed [31:0] inv_r1c0;
        logic signed [31:0] inv_r1c1;
        logic signed [31:0] inv_r1c2;
        logic signed [31:0] inv_r2c0;
        logic signed [31:0] inv_r2c1;
        logic signed [31:0] inv_r2c2;
        logic               invertible;
        logic signed [31:0] determinant;
    } out_word_t;

endpackage

`default_nettype wire

// ===== src/matrix3_inverse_top.sv =====
// channel   | ports                     | handshake
// ----------+---------------------------+------------------------------------
// input     | start, busy, m            | word taken when start && !busy
// result    | done, res                 | word valid for the one cycle done=1
// config    | cfg_we, cfg_wdata         | threshold written when cfg_we=1
//
// Fully pipelined: one matrix per cycle while busy is low
// (6 cofactor/determinant stages, 128 reciprocal stages, 4 multiply stages).
// The 128-step restoring division for 2^127/|D| sets the depth: one quotient
// bit per stage.
// busy is high only during reset and the first cycle after; otherwise words
// are always taken. The receiver cannot stall; results leave on schedule.
// Reset is asynchronous, active low; it clears the valid line and sets the
// threshold to 1.
`default_nettype none
`include "matrix3_inverse_top_assert.svh"

module matrix3_inverse_top #(
    parameter int FRAC_BITS = m3inv_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire m3inv_pkg::in_word_t         m,
    input  wire logic                        cfg_we,
    input  wire logic [m3inv_pkg::THR_W-1:0] cfg_wdata,
    output logic                             done,
    output m3inv_pkg::out_word_t             res
);
    import m3inv_pkg::*;

    localparam int SH        = 2 * FRAC_BITS;      // fraction bits of a minor
    localparam int S         = 127 - SH;           // final product shift
    localparam int DIV_STEPS = 128;
    localparam int DET_W     = 98;                 // |D| < 3*2^94
    localparam int MAG_W     = 96;
    localparam int LAT       = 6 + DIV_STEPS + 4;

    localparam logic [191:0] LIM_POS = 192'(32'h7FFF_FFFF);
    localparam logic [191:0] LIM_NEG = 192'(32'h8000_0000);

    // side data riding along with the reciprocal
    typedef struct packed {
        logic [8:0]        neg;
        logic [8:0][63:0]  cm;
        logic              sing;
        logic [31:0]       det_out;
    } carry_t;

    logic [THR_W-1:0] thr_reg;
    logic             busy_reg;
    logic [LAT-1:0]   v_reg;
    logic [LAT-1:0]   v_next;

    assign v_next = {v_reg[LAT-2:0], start & ~busy_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_RESET;
            busy_reg <= 1'b1;
            v_reg    <= '0;
        end
        else
        begin
            busy_reg <= 1'b0;
            v_reg    <= v_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
        end
    end

    assign busy = busy_reg;
    assign done = v_reg[LAT-1];

    // ---------------- stage 1: minor products ----------------
    logic signed [31:0] a [9];
    logic signed [63:0] pa_next [9];
    logic signed [63:0] pb_next [9];
    logic signed [63:0] s1_pa_reg [9];
    logic signed [63:0] s1_pb_reg [9];
    logic signed [31:0] s1_a_reg [3];

    assign a[0] = m.m_r0c0;
    assign a[1] = m.m_r0c1;
    assign a[2] = m.m_r0c2;
    assign a[3] = m.m_r1c0;
    assign a[4] = m.m_r1c1;
    assign a[5] = m.m_r1c2;
    assign a[6] = m.m_r2c0;
    assign a[7] = m.m_r2c1;
    assign a[8] = m.m_r2c2;

    // adjugate entry k = pa[k] - pb[k], cofactor sign folded in
    always_comb
    begin
        pa_next[0] = a[4] * a[8];  pb_next[0] = a[7] * a[5];
        pa_next[3] = a[6] * a[5];  pb_next[3] = a[3] * a[8];
        pa_next[6] = a[3] * a[7];  pb_next[6] = a[6] * a[4];
        pa_next[1] = a[7] * a[2];  pb_next[1] = a[1] * a[8];
        pa_next[4] = a[0] * a[8];  pb_next[4] = a[6] * a[2];
        pa_next[7] = a[6] * a[1];  pb_next[7] = a[0] * a[7];
        pa_next[2] = a[1] * a[5];  pb_next[2] = a[4] * a[2];
        pa_next[5] = a[3] * a[2];  pb_next[5] = a[0] * a[5];
        pa_next[8] = a[0] * a[4];  pb_next[8] = a[3] * a[1];
    end

    // ---------------- stages 2..6 ----------------
    logic signed [63:0]      s2_adj_reg [9];
    logic signed [31:0]      s2_a_reg [3];
    logic [63:0]             s3_lo_reg [3];
    logic [63:0]             s3_hi_reg [3];
    logic [2:0]              s3_sg_reg;
    logic signed [63:0]      s3_adj_reg [9];
    logic signed [DET_W-1:0] s4_term_reg [3];
    logic signed [63:0]      s4_adj_reg [9];
    logic signed [DET_W-1:0] s5_det_reg;
    logic signed [63:0]      s5_adj_reg [9];

    logic [31:0]             am [3];
    logic [63:0]             adm [3];
    logic [MAG_W-1:0]        tmag [3];
    logic signed [DET_W-1:0] term_next [3];

    always_comb
    begin
        for (int t = 0; t < 3; t++)
        begin
            am[t]  = s2_a_reg[t][31] ? 32'(-s2_a_reg[t]) : 32'(s2_a_reg[t]);
            adm[t] = s2_adj_reg[3*t][63] ? 64'(-s2_adj_reg[3*t]) : 64'(s2_adj_reg[3*t]);
            tmag[t] = (MAG_W'(s3_hi_reg[t]) << 32) + MAG_W'(s3_lo_reg[t]);
            term_next[t] = s3_sg_reg[t] ? -$signed({2'b00, tmag[t]})
                                        :  $signed({2'b00, tmag[t]});
        end
    end

    // stage 6: magnitude, saturated determinant, singular test
    logic              dneg;
    logic [DET_W-1:0]  dabs;
    logic [MAG_W-1:0]  dmag;
    logic signed [DET_W-1:0] dsh;
    logic [DET_W-32:0] dtop;
    logic [MAG_W-1:0]  thr_sh;
    carry_t            c6_next;
    carry_t            c6_reg;
    logic [MAG_W-1:0]  d6_reg;

    always_comb
    begin
        dneg   = s5_det_reg[DET_W-1];
        dabs   = dneg ? DET_W'(-s5_det_reg) : DET_W'(s5_det_reg);
        dmag   = dabs[MAG_W-1:0];
        dsh    = s5_det_reg >>> SH;
        dtop   = dsh[DET_W-1:31];
        thr_sh = MAG_W'(thr_reg) << SH;
        c6_next.sing = (dmag == '0) || (dmag < thr_sh);
        if ((&dtop) || !(|dtop))
        begin
            c6_next.det_out = dsh[31:0];
        end
        else
        begin
            c6_next.det_out = dneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        for (int k = 0; k < 9; k++)
        begin
            c6_next.cm[k]  = s5_adj_reg[k][63] ? 64'(-s5_adj_reg[k]) : 64'(s5_adj_reg[k]);
            c6_next.neg[k] = s5_adj_reg[k][63] ^ dneg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pa_reg <= pa_next;
        s1_pb_reg <= pb_next;
        s1_a_reg  <= '{a[0], a[1], a[2]};
        for (int k = 0; k < 9; k++)
        begin
            s2_adj_reg[k] <= s1_pa_reg[k] - s1_pb_reg[k];
        end
        s2_a_reg <= s1_a_reg;
        for (int t = 0; t < 3; t++)
        begin
            s3_lo_reg[t] <= 64'(am[t]) * 64'(adm[t][31:0]);
            s3_hi_reg[t] <= 64'(am[t]) * 64'(adm[t][63:32]);
            s3_sg_reg[t] <= s2_a_reg[t][31] ^ s2_adj_reg[3*t][63];
        end
        s3_adj_reg  <= s2_adj_reg;
        s4_term_reg <= term_next;
        s4_adj_reg  <= s3_adj_reg;
        s5_det_reg  <= s4_term_reg[0] + s4_term_reg[1] + s4_term_reg[2];
        s5_adj_reg  <= s4_adj_reg;
        c6_reg      <= c6_next;
        d6_reg      <= dmag;
    end

    // ---------------- reciprocal: floor(2^127 / |D|), one bit per stage ----------------
    logic [MAG_W-1:0] dv_d_reg   [DIV_STEPS];
    logic [MAG_W-1:0] dv_rem_reg [DIV_STEPS];
    logic [127:0]     dv_q_reg   [DIV_STEPS];
    carry_t           dv_c_reg   [DIV_STEPS];

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        logic [MAG_W-1:0] d_in;
        logic [MAG_W-1:0] rem_in;
        logic [127:0]     q_in;
        carry_t           c_in;
        logic [MAG_W:0]   rem_sh;
        logic             ge;

        if (i == 0)
        begin : g_first
            assign d_in   = d6_reg;
            assign rem_in = '0;
            assign q_in   = '0;
            assign c_in   = c6_reg;
        end
        else
        begin : g_rest
            assign d_in   = dv_d_reg[i-1];
            assign rem_in = dv_rem_reg[i-1];
            assign q_in   = dv_q_reg[i-1];
            assign c_in   = dv_c_reg[i-1];
        end

        // the dividend's only set bit enters at the first step
        assign rem_sh = {rem_in, (i == 0) ? 1'b1 : 1'b0};
        assign ge     = rem_sh >= {1'b0, d_in};

        always_ff @(posedge clk)
        begin
            dv_d_reg[i]   <= d_in;
            dv_rem_reg[i] <= ge ? MAG_W'(rem_sh - {1'b0, d_in}) : rem_sh[MAG_W-1:0];
            dv_q_reg[i]   <= {q_in[126:0], ge};
            dv_c_reg[i]   <= c_in;
        end
    end

    // ---------------- adjugate times reciprocal ----------------
    logic [127:0]  rcp;
    carry_t        cl;
    logic [63:0]   pp_reg  [9][2][4];
    logic [159:0]  row_reg [9][2];
    logic [191:0]  full_reg [9];
    carry_t        cp_reg;
    carry_t        cq_reg;
    carry_t        cz_reg;

    assign rcp = dv_q_reg[DIV_STEPS-1];
    assign cl  = dv_c_reg[DIV_STEPS-1];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
        begin
            for (int i = 0; i < 2; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    pp_reg[k][i][j] <= 64'(cl.cm[k][32*i +: 32]) * 64'(rcp[32*j +: 32]);
                end
                // even and odd partials do not overlap: two concatenations, one add
                row_reg[k][i] <= 160'({pp_reg[k][i][2], pp_reg[k][i][0]})
                               + {pp_reg[k][i][3], pp_reg[k][i][1], 32'b0};
            end
            full_reg[k] <= 192'(row_reg[k][0]) + {row_reg[k][1], 32'b0};
        end
        cp_reg <= cl;
        cq_reg <= cp_reg;
        cz_reg <= cq_reg;
    end

    // ---------------- output register ----------------
    logic [191:0]      qv [9];
    logic [31:0]       qm [9];
    logic [8:0][31:0]  inv_val;
    out_word_t         res_next;
    out_word_t         res_reg;

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            qv[k] = full_reg[k] >> S;
            if (cz_reg.neg[k])
            begin
                qm[k] = (qv[k] > LIM_NEG) ? LIM_NEG[31:0] : qv[k][31:0];
            end
            else
            begin
                qm[k] = (qv[k] > LIM_POS) ? LIM_POS[31:0] : qv[k][31:0];
            end
            inv_val[k] = cz_reg.sing ? 32'd0 : (cz_reg.neg[k] ? 32'(-qm[k]) : qm[k]);
        end
        res_next.inv_r0c0    = inv_val[0];
        res_next.inv_r0c1    = inv_val[1];
        res_next.inv_r0c2    = inv_val[2];
        res_next.inv_r1c0    = inv_val[3];
        res_next.inv_r1c1    = inv_val[4];
        res_next.inv_r1c2    = inv_val[5];
        res_next.inv_r2c0    = inv_val[6];
        res_next.inv_r2c1    = inv_val[7];
        res_next.inv_r2c2    = inv_val[8];
        res_next.invertible  = ~cz_reg.sing;
        res_next.determinant = cz_reg.det_out;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

    // ---------------- checks ----------------
    `M3INV_ASSERT_AFTER(a_done_latency, start && !busy, LAT, done, "result word missing")
    `M3INV_ASSERT_NOW(a_no_spurious, done, $past(start && !busy, LAT), "unexpected result word")
    `M3INV_ASSERT_NOW(a_singular_zero, done && !res.invertible,
        res.inv_r0c0 == 0 && res.inv_r1c1 == 0 && res.inv_r2c2 == 0 && res.inv_r0c2 == 0,
        "singular word with nonzero inverse")

endmodule

`default_nettype wire

// ===== tb/sv/tb_matrix3_inverse_top.sv =====
`default_nettype none

module tb_matrix3_inverse_top;
    import m3inv_pkg::*;

    localparam int FRAC     = FRAC_BITS_DEF;
    localparam int WDOG_MAX = 4000;   // cycles with no traffic before giving up
    localparam int DRAIN    = 160;    // pipeline depth plus margin

    localparam logic [31:0] Q_ONE = 32'h0001_0000;
    localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S_MIN = 32'h8000_0000;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    in_word_t         m;
    logic             cfg_we;
    logic [THR_W-1:0] cfg_wdata;
    logic             done;
    out_word_t        res;

    matrix3_inverse_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .m         (m),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .res       (res)
    );

    // Local copy of the threshold register.
    logic [THR_W-1:0] thr_shadow;
    // Inverse words still to come out, oldest first.
    out_word_t        pending_inv[$];
    int               mismatches;
    int               idle_cycles;
    bit               gaps_on;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Exact determinant / adjugate / reciprocal arithmetic on wide vectors.
    function automatic out_word_t predict_inverse(in_word_t w);
        logic [287:0]        flat;
        logic signed [31:0]  t;
        logic signed [63:0]  a[9];
        logic signed [63:0]  adj[9];
        logic signed [127:0] d;
        logic signed [127:0] dq;
        logic [127:0]        mag;
        logic [127:0]        thr_full;
        logic [255:0]        rcp;
        logic [255:0]        q;
        logic [63:0]         am;
        logic [31:0]         lim;
        logic [31:0]         e[9];
        logic [31:0]         detv;
        logic                dneg;
        logic                neg;
        flat = w;
        for (int k = 0; k < 9; k++)
        begin
            t    = flat[287 - 32*k -: 32];
            a[k] = t;
        end
        adj[0] =  (a[4] * a[8] - a[7] * a[5]);
        adj[3] = -(a[3] * a[8] - a[6] * a[5]);
        adj[6] =  (a[3] * a[7] - a[6] * a[4]);
        adj[1] = -(a[1] * a[8] - a[7] * a[2]);
        adj[4] =  (a[0] * a[8] - a[6] * a[2]);
        adj[7] = -(a[0] * a[7] - a[6] * a[1]);
        adj[2] =  (a[1] * a[5] - a[4] * a[2]);
        adj[5] = -(a[0] * a[5] - a[3] * a[2]);
        adj[8] =  (a[0] * a[4] - a[3] * a[1]);
        d    = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
        dneg = d < 0;
        mag  = dneg ? -d : d;

        // Determinant back at FRAC fraction bits: floor, then clamp.
        dq = d >>> (2*FRAC);
        if (dq > 128'sh7FFF_FFFF)
            detv = S_MAX;
        else if (dq < -128'sh8000_0000)
            detv = S_MIN;
        else
            detv = dq[31:0];

        thr_full = {97'b0, thr_shadow} << (2*FRAC);
        if (mag == 0 || mag < thr_full)
            return {288'b0, 1'b0, detv};

        rcp = (256'd1 << 127) / {128'b0, mag};
        for (int k = 0; k < 9; k++)
        begin
            am  = adj[k] < 0 ? -adj[k] : adj[k];
            neg = (adj[k] < 0) != dneg;
            q   = ({192'b0, am} * rcp) >> (127 - 2*FRAC);
            lim = neg ? S_MIN : S_MAX;
            if (q > {224'b0, lim})
                q = {224'b0, lim};
            e[k] = neg ? -q[31:0] : q[31:0];
        end
        return {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8], 1'b1, detv};
    endfunction

    // Result checker: done is sampled mid-cycle, away from the driving edge.
    always @(negedge clk)
    begin
        out_word_t exp_w;
        logic [320:0] ev;
        logic [320:0] av;
        bit bad;
        if (rst_n && done)
        begin
            if (pending_inv.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", res);
            end
            else
            begin
                exp_w = pending_inv.pop_front();
                ev = exp_w;
                av = res;
                bad = 1'b0;
                // nine inverse entries, then invertible, then determinant
                for (int k = 0; k < 9; k++)
                    if (ev[320 - 32*k -: 32] !== av[320 - 32*k -: 32])
                    begin
                        bad = 1'b1;
                        if (mismatches < 10)
                            $display("inv entry r%0dc%0d: exp %h got %h", k / 3, k % 3,
                                     ev[320 - 32*k -: 32], av[320 - 32*k -: 32]);
                    end
                if (exp_w.invertible !== res.invertible)
                begin
                    bad = 1'b1;
                    if (mismatches < 10)
                        $display("invertible: exp %b got %b",
                                 exp_w.invertible, res.invertible);
                end
                if (exp_w.determinant !== res.determinant)
                begin
                    bad = 1'b1;
                    if (mismatches < 10)
                        $display("determinant: exp %h got %h",
                                 exp_w.determinant, res.determinant);
                end
                if (bad)
                    mismatches++;
            end
        end
    end

    // Watchdog on traffic of either kind.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("tb_matrix3_inverse_top NOT OK");
            $finish;
        end
    end

    // Present one matrix word, hold it until taken, then maybe leave a gap.
    task automatic send_matrix(input in_word_t w);
        bit taken;
        start <= 1'b1;
        m     <= w;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !busy;   // busy only moves on the rising edge
            @(posedge clk);
        end
        pending_inv.push_back(predict_inverse(w));
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // Threshold writes only with the pipeline empty; every item yields a word.
    task automatic set_threshold(input logic [THR_W-1:0] v);
        start <= 1'b0;
        while (pending_inv.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        thr_shadow = v;
    endtask

    function automatic in_word_t diag3(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        return {x, 32'd0, 32'd0, 32'd0, y, 32'd0, 32'd0, 32'd0, z};
    endfunction

    function automatic logic [31:0] pick_entry(int style);
        logic [31:0] v;
        case (style)
            0: v = $urandom;
            // roughly within +/-8.0: ordinary well-scaled matrices
            1: v = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            // tiny values: near the singular threshold
            2: v = $urandom_range(0, 600) - 300;
            default:
                case ($urandom_range(0, 6))
                    0: v = S_MAX;
                    1: v = S_MIN;
                    2: v = 32'd0;
                    3: v = Q_ONE;
                    4: v = -Q_ONE;
                    5: v = 32'hFFFF_FFFF;
                    default: v = 32'd1;
                endcase
        endcase
        return v;
    endfunction

    function automatic in_word_t random_matrix();
        logic [31:0] e[9];
        int style;
        style = $urandom_range(0, 9);
        for (int k = 0; k < 9; k++)
            e[k] = pick_entry(style < 3 ? 0 : style < 7 ? 1 : style < 8 ? 2 : 3);
        // sometimes make row 2 almost a copy of row 0: near singular
        if ($urandom_range(0, 5) == 0)
            for (int k = 0; k < 3; k++)
                e[6 + k] = e[k] + $urandom_range(0, 4) - 2;
        return {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    endfunction

    task automatic test_directed();
        send_matrix(diag3(Q_ONE, Q_ONE, Q_ONE));                  // identity
        send_matrix('0);                                          // zero matrix
        send_matrix(diag3(Q_ONE << 1, Q_ONE << 1, Q_ONE << 1));   // 2*I
        send_matrix(diag3(-Q_ONE, Q_ONE, Q_ONE));                 // negative det
        send_matrix(diag3(Q_ONE, Q_ONE, 32'd1));                  // det exactly at threshold
        send_matrix(diag3(Q_ONE, Q_ONE >> 1, 32'd1));             // just below threshold
        send_matrix(diag3(32'd2, Q_ONE, Q_ONE));                  // huge inverse, saturates
        send_matrix(diag3(-32'd2, Q_ONE, Q_ONE));                 // saturates negative
        send_matrix(diag3(S_MAX, S_MAX, S_MAX));                  // det saturates high
        send_matrix(diag3(S_MIN, S_MAX, S_MAX));                  // det saturates low
        send_matrix({9{S_MIN}});                                  // all min, singular
        send_matrix({9{S_MAX}});
        send_matrix({S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MAX, S_MIN, S_MIN});
        send_matrix({9{32'hFFFF_FFFF}});
        send_matrix({Q_ONE, Q_ONE << 1, 32'd0, 32'd0, Q_ONE, Q_ONE * 3,
                     Q_ONE, 32'd0, Q_ONE});                      // general integer matrix
        send_matrix({32'd0, Q_ONE, 32'd0, Q_ONE, 32'd0, 32'd0,
                     32'd0, 32'd0, Q_ONE});                      // permutation
    endtask

    // Extremes of the threshold, with the zero determinant always singular.
    task automatic test_thresholds();
        logic [THR_W-1:0] vals[4];
        vals = '{31'd0, 31'h7FFF_FFFF, 31'h0001_0000, 31'd5};
        foreach (vals[i])
        begin
            set_threshold(vals[i]);
            send_matrix('0);
            send_matrix(diag3(32'd1, 32'd1, 32'd1));
            send_matrix(diag3(Q_ONE, Q_ONE, Q_ONE));
            send_matrix(diag3(S_MAX, S_MAX, 32'd1));
            send_matrix(diag3(Q_ONE, Q_ONE, 32'(vals[i]) & 32'hFF));
            for (int n = 0; n < 15; n++)
                send_matrix(random_matrix());
        end
    endtask

    task automatic test_random();
        for (int n = 0; n < 840; n++)
        begin
            if (n % 210 == 0)
                set_threshold(n == 0 ? 31'd1 : 31'($urandom));
            if (n == 700)
                gaps_on = 1'b0;   // closing stretch runs back to back
            send_matrix(random_matrix());
        end
    endtask

    initial
    begin
        start       = 1'b0;
        m           = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        rst_n       = 1'b0;
        mismatches  = 0;
        idle_cycles = 0;
        gaps_on     = 1'b1;
        thr_shadow  = THR_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_thresholds();
        test_random();

        start <= 1'b0;
        while (pending_inv.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (mismatches == 0)
            $display("tb_matrix3_inverse_top OK");
        else
            $display("tb_matrix3_inverse_top NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
